// ===== rtl/lrbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrbs_pkg: shared types and constants for the link reconnect sequencer
// Beat layouts, action codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package lrbs_pkg;

    // Action codes carried in each result beat
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_ATTEMPT    = 3'd1,
        ACT_COOL_START = 3'd2,
        ACT_COOL_END   = 3'd3,
        ACT_GAINED     = 3'd4,
        ACT_LOST       = 3'd5
    } action_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ATTEMPTS = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_FLOOR    = 2'd2,
        CFG_CEILING  = 2'd3
    } cfg_idx_t;

    localparam int unsigned CFG_DATA_W = 22;
    localparam int unsigned COOL_W     = 22;
    localparam int unsigned TIMEOUT_W  = 20;
    localparam int unsigned ATTEMPT_W  = 4;

    localparam logic [ATTEMPT_W-1:0] ATTEMPTS_RST = 4'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 20'd20000;
    localparam logic [COOL_W-1:0]    FLOOR_RST    = 22'd60000;
    localparam logic [COOL_W-1:0]    CEILING_RST  = 22'd900000;

    localparam logic [31:0] LINK_LOST_DELAY_MS = 32'd5000;
    localparam logic [31:0] RESTART_DELAY_MS   = 32'd1000;

    // One poll tick
    typedef struct packed {
        logic [31:0] now_ms;
        logic        link_up;
        logic [3:0]  network_count;
        logic        restart_request;
    } tick_t;

    // One action record
    typedef struct packed {
        action_t            action;
        logic [2:0]         network_index;
        logic [3:0]         attempt_number;
        logic [COOL_W-1:0]  cooldown_used_ms;
    } result_t;

endpackage

// ===== rtl/link_reconnect_backoff_sequencer.sv =====
// ----------------------------------------------------------------------------
// link_reconnect_backoff_sequencer: reconnect retries with escalating cooldown
// Two registers (tick register, then result register); one tick per cycle while
// act_ready lets the result register drain. State updates between the two registers.
// Async active-low reset: config to defaults, sequence idle, cooldown = floor.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_sequencer #(
    parameter int unsigned MAX_NETWORKS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // poll ticks
    input  logic                           tick_valid,
    output logic                           tick_ready,
    input  lrbs_pkg::tick_t                tick,
    // action records
    output logic                           act_valid,
    input  logic                           act_ready,
    output lrbs_pkg::result_t              act,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  lrbs_pkg::cfg_idx_t             cfg_index,
    input  logic [lrbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lrbs_pkg::*;

    // try index must hold MAX_NETWORKS itself for the one-past-end check
    localparam int unsigned IDX_W = $clog2(MAX_NETWORKS + 1);
    // common width for comparing the index against the saved count
    localparam int unsigned CMP_W = IDX_W + 4;

    // ---------------------------------------------------------------------
    // Configuration registers. Writes must only arrive while idle (not enforced
    // by this block); they are always taken.
    // ---------------------------------------------------------------------
    logic [ATTEMPT_W-1:0] attempts_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [COOL_W-1:0]    floor_reg;
    logic [COOL_W-1:0]    ceiling_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempts_reg <= ATTEMPTS_RST;
            timeout_reg  <= TIMEOUT_RST;
            floor_reg    <= FLOOR_RST;
            ceiling_reg  <= CEILING_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ATTEMPTS: attempts_reg <= cfg_data[ATTEMPT_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                CFG_FLOOR:    floor_reg    <= cfg_data[COOL_W-1:0];
                CFG_CEILING:  ceiling_reg  <= cfg_data[COOL_W-1:0];
                default:      attempts_reg <= attempts_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Two-register pipe: tick register -> state update -> result register.
    // The state is written on the same edge that loads the result, so the
    // next tick in the tick register always sees fully updated state.
    // ---------------------------------------------------------------------
    logic    in_full_reg;
    tick_t   in_data_reg;
    logic    out_full_reg;
    result_t out_data_reg;
    logic    advance;

    assign advance    = in_full_reg && (!out_full_reg || act_ready);
    assign tick_ready = !in_full_reg || advance;
    assign act_valid  = out_full_reg;
    assign act        = out_data_reg;

    // sequencer state
    logic                 was_linked_reg,   was_linked_next;
    logic [IDX_W-1:0]     try_index_reg,    try_index_next;
    logic [ATTEMPT_W-1:0] try_count_reg,    try_count_next;
    logic [31:0]          next_time_reg,    next_time_next;
    logic                 cooling_reg,      cooling_next;
    logic [31:0]          cool_until_reg,   cool_until_next;
    logic [COOL_W-1:0]    cool_len_reg,     cool_len_next;

    result_t              result_next;

    // ---------------------------------------------------------------------
    // Per-tick step. Order: restart request, link edges, then the retry
    // sequence while the link is down. At most one action per tick.
    // ---------------------------------------------------------------------
    always_comb
    begin
        logic [ATTEMPT_W-1:0] limit;
        logic [CMP_W-1:0]     count_ext;
        logic [CMP_W-1:0]     max_ext;
        logic [CMP_W-1:0]     count_c;
        logic [COOL_W:0]      doubled;
        logic [31:0]          idx_wide;
        logic                 up;
        logic [31:0]          now;
        action_t              act_code;
        logic [COOL_W-1:0]    used;

        was_linked_next = was_linked_reg;
        try_index_next  = try_index_reg;
        try_count_next  = try_count_reg;
        next_time_next  = next_time_reg;
        cooling_next    = cooling_reg;
        cool_until_next = cool_until_reg;
        cool_len_next   = cool_len_reg;
        act_code        = ACT_NONE;
        used            = '0;

        up  = in_data_reg.link_up;
        now = in_data_reg.now_ms;

        // zero attempts counts as one
        limit = (attempts_reg == '0) ? ATTEMPT_W'(1) : attempts_reg;

        // oversize counts clamp to the table size
        count_ext = CMP_W'(in_data_reg.network_count);
        max_ext   = CMP_W'(MAX_NETWORKS);
        count_c   = (count_ext > max_ext) ? max_ext : count_ext;

        doubled = {cool_len_reg, 1'b0};

        if (in_data_reg.restart_request && !up)
        begin
            try_index_next = '0;
            try_count_next = '0;
            cooling_next   = 1'b0;
            next_time_next = now + RESTART_DELAY_MS;
        end

        if (up && !was_linked_reg)
        begin
            was_linked_next = 1'b1;
            try_index_next  = '0;
            try_count_next  = '0;
            cooling_next    = 1'b0;
            cool_len_next   = floor_reg;
            act_code        = ACT_GAINED;
        end

        if (!up && was_linked_reg)
        begin
            was_linked_next = 1'b0;
            try_index_next  = '0;
            try_count_next  = '0;
            cooling_next    = 1'b0;
            next_time_next  = now + LINK_LOST_DELAY_MS;
            act_code        = ACT_LOST;
        end

        if (!up && (count_c != '0))
        begin
            if (cooling_next)
            begin
                if (now >= cool_until_reg)
                begin
                    cooling_next   = 1'b0;
                    try_index_next = '0;
                    try_count_next = '0;
                    next_time_next = now;
                    act_code       = ACT_COOL_END;
                end
            end
            else if (now >= next_time_next)
            begin
                if (try_count_next >= limit)
                begin
                    try_index_next = try_index_next + IDX_W'(1);
                    try_count_next = '0;
                end
                // stale or exhausted index: whole round failed
                if (CMP_W'(try_index_next) >= count_c)
                begin
                    cooling_next    = 1'b1;
                    cool_until_next = now + 32'(cool_len_reg);
                    try_index_next  = '0;
                    try_count_next  = '0;
                    used            = cool_len_reg;
                    cool_len_next   = (doubled < (COOL_W+1)'(ceiling_reg))
                                      ? doubled[COOL_W-1:0] : ceiling_reg;
                    act_code        = ACT_COOL_START;
                end
                else
                begin
                    try_count_next = try_count_next + ATTEMPT_W'(1);
                    next_time_next = now + 32'(timeout_reg);
                    act_code       = ACT_ATTEMPT;
                end
            end
        end

        idx_wide = 32'(try_index_next);

        result_next.action           = act_code;
        result_next.network_index    = idx_wide[2:0];
        result_next.attempt_number   = try_count_next;
        result_next.cooldown_used_ms = used;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            out_full_reg   <= 1'b0;
            was_linked_reg <= 1'b0;
            try_index_reg  <= '0;
            try_count_reg  <= '0;
            next_time_reg  <= '0;
            cooling_reg    <= 1'b0;
            cool_until_reg <= '0;
            cool_len_reg   <= FLOOR_RST;
        end
        else
        begin
            if (tick_valid && tick_ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance)
            begin
                out_full_reg <= 1'b1;
            end
            else if (act_ready)
            begin
                out_full_reg <= 1'b0;
            end

            if (advance)
            begin
                was_linked_reg <= was_linked_next;
                try_index_reg  <= try_index_next;
                try_count_reg  <= try_count_next;
                next_time_reg  <= next_time_next;
                cooling_reg    <= cooling_next;
                cool_until_reg <= cool_until_next;
                cool_len_reg   <= cool_len_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            in_data_reg <= tick;
        end
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

endmodule
